FILE: src/eabv_pkg.sv
`default_nettype none

package eabv_pkg;

  // Fraction bits of the internal quarter-turn argument and of the series coefficients.
  localparam int unsigned QBits = 30;

  // Width of the argument t, which may reach a full 1.0 in Q30.
  localparam int unsigned TW = 31;

  // Width of the sine magnitude before rounding, held with 31 fraction bits.
  localparam int unsigned S31W = 32;

  // Number of coefficients in the odd Taylor series of sin(pi/2 * t).
  localparam int unsigned NumCoef = 7;

  // Register stages of the sine and cosine unit: argument, square,
  // one stage per Horner step, final product and rounding.
  localparam int unsigned ScLatency = NumCoef + 3;

  // Register stages of the rounding fixed-point multiplier.
  localparam int unsigned QmulLatency = 2;

  // Q30 series coefficients, highest order first.
  function automatic logic [TW-1:0] sin_coef(input logic [2:0] k);
    logic [TW-1:0] c;
    unique case (k)
      3'd0:    c = TW'(61);
      3'd1:    c = TW'(3864);
      3'd2:    c = TW'(172272);
      3'd3:    c = TW'(5026995);
      3'd4:    c = TW'(85569306);
      3'd5:    c = TW'(693598668);
      3'd6:    c = TW'(1686629713);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/eabv_sincos.sv
`default_nettype none

module eabv_sincos #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ANGLE_BITS-1:0]       angle_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] sin_o,
  output logic signed [FRAC_BITS+1:0] cos_o
);
  import eabv_pkg::*;

  localparam int unsigned OffBits   = ANGLE_BITS - 2;
  localparam int unsigned OffShift  = QBits - OffBits;
  localparam int unsigned OutW      = FRAC_BITS + 2;
  localparam int unsigned RndShift  = QBits - FRAC_BITS;
  localparam int unsigned ProdStage = NumCoef + 1;
  localparam int unsigned NumLanes  = 2;
  localparam logic [TW-1:0]   QOneT = TW'(1) << QBits;
  localparam logic [S31W-1:0] OneS  = S31W'(1) << FRAC_BITS;

  // Lane 0 carries the sine, lane 1 the cosine of the same angle.
  logic [ScLatency-1:0] vld_q;
  logic [TW-1:0]        t_q   [0:NumCoef][NumLanes];
  logic [TW-1:0]        u_q   [1:NumCoef-1][NumLanes];
  logic [TW-1:0]        p_q   [1:NumCoef][NumLanes];
  logic [1:0]           neg_q [0:ProdStage];
  logic [S31W-1:0]      s31_q [NumLanes];
  logic [OutW-1:0]      res_q [NumLanes];

  logic [1:0]           quad;
  logic [TW-1:0]        t0, t1;
  logic [TW-1:0]        t_d   [NumLanes];
  logic [1:0]           neg_d;
  logic [TW-1:0]        u_d   [NumLanes];
  logic [TW-1:0]        p_d   [2:NumCoef][NumLanes];
  logic [S31W-1:0]      s31_d [NumLanes];
  logic [OutW-1:0]      res_d [NumLanes];

  // Split the angle into quadrant and offset; the cosine is a quarter turn ahead.
  always_comb begin
    quad   = angle_i[ANGLE_BITS-1 -: 2];
    t0     = TW'(angle_i[OffBits-1:0]) << OffShift;
    t1     = QOneT - t0;
    t_d[0] = quad[0] ? t1 : t0;
    t_d[1] = quad[0] ? t0 : t1;
    neg_d  = {quad[1] ^ quad[0], quad[1]};
  end

  // One multiplication per stage for the square, the Horner steps and the final product; the last stage rounds.
  always_comb begin
    logic [2*TW-1:0] sq    [NumLanes];
    logic [2*TW-1:0] hp    [2:NumCoef][NumLanes];
    logic [2*TW-1:0] tp    [NumLanes];
    logic [S31W:0]   rnd   [NumLanes];
    logic [S31W-1:0] half  [NumLanes];
    logic [S31W-1:0] mag   [NumLanes];
    for (int l = 0; l < NumLanes; l++) begin
      sq[l]  = t_q[0][l] * t_q[0][l];
      u_d[l] = sq[l][QBits +: TW];
      for (int s = 2; s <= NumCoef; s++) begin
        hp[s][l]  = p_q[s-1][l] * u_q[s-1][l];
        p_d[s][l] = sin_coef(3'(s - 1)) - hp[s][l][QBits +: TW];
      end
      tp[l]    = t_q[NumCoef][l] * p_q[NumCoef][l];
      s31_d[l] = tp[l][QBits-1 +: S31W];
      rnd[l]   = ({1'b0, s31_q[l]} >> RndShift) + (S31W+1)'(1);
      half[l]  = rnd[l][S31W:1];
      mag[l]   = (half[l] > OneS) ? OneS : half[l];
      res_d[l] = neg_q[ProdStage][l] ? OutW'(0) - OutW'(mag[l]) : OutW'(mag[l]);
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ScLatency-2:0], valid_i};
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    neg_q[0] <= neg_d;
    for (int s = 1; s <= ProdStage; s++) begin
      neg_q[s] <= neg_q[s-1];
    end
    for (int l = 0; l < NumLanes; l++) begin
      t_q[0][l] <= t_d[l];
      u_q[1][l] <= u_d[l];
      p_q[1][l] <= sin_coef(3'(0));
      for (int s = 1; s <= NumCoef; s++) begin
        t_q[s][l] <= t_q[s-1][l];
      end
      for (int s = 2; s <= NumCoef - 1; s++) begin
        u_q[s][l] <= u_q[s-1][l];
      end
      for (int s = 2; s <= NumCoef; s++) begin
        p_q[s][l] <= p_d[s][l];
      end
      s31_q[l] <= s31_d[l];
      res_q[l] <= res_d[l];
    end
  end

  assign valid_o = vld_q[ScLatency-1];
  assign sin_o   = $signed(res_q[0]);
  assign cos_o   = $signed(res_q[1]);

endmodule

`default_nettype wire

FILE: src/eabv_qmul.sv
`default_nettype none

module eabv_qmul #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+1:0] a_i,
  input  logic signed [FRAC_BITS+1:0] b_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] p_o
);
  import eabv_pkg::*;

  localparam int unsigned OutW  = FRAC_BITS + 2;
  localparam int unsigned MagW  = FRAC_BITS + 1;
  localparam int unsigned ProdW = 2 * MagW;
  localparam logic [ProdW-1:0] Half = ProdW'(1) << (FRAC_BITS - 1);

  logic [QmulLatency-1:0] vld_q;
  logic [ProdW-1:0]       prod_q;
  logic                   neg_q;
  logic [OutW-1:0]        res_q;

  logic [OutW-1:0]  na, nb;
  logic [MagW-1:0]  ma, mb;
  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] sum;
  logic [MagW-1:0]  mag;
  logic [OutW-1:0]  res_d;

  // First stage multiplies the magnitudes; the second rounds half away from zero.
  always_comb begin
    na     = OutW'(0) - a_i;
    nb     = OutW'(0) - b_i;
    ma     = a_i[OutW-1] ? na[MagW-1:0] : a_i[MagW-1:0];
    mb     = b_i[OutW-1] ? nb[MagW-1:0] : b_i[MagW-1:0];
    prod_d = ma * mb;
    sum    = prod_q + Half;
    mag    = sum[FRAC_BITS +: MagW];
    res_d  = neg_q ? OutW'(0) - OutW'(mag) : OutW'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QmulLatency-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= a_i[OutW-1] ^ b_i[OutW-1];
    res_q  <= res_d;
  end

  assign valid_o = vld_q[QmulLatency-1];
  assign p_o     = $signed(res_q);

endmodule

`default_nettype wire

FILE: src/euler_angles_to_basis_vectors.sv
`default_nettype none

// Orientation to basis vectors.
// A word of three binary angles (pitch, yaw, roll, 2^ANGLE_BITS units to a
// turn) is taken at a rising edge where start_i is high and busy_o is low.
// busy_o is always low: a new word may be started in every cycle.
// The forward, right and up unit vectors come out on their own ports in
// signed fixed point with FRAC_BITS fraction bits, each component held to
// plus or minus one. done_o marks them for exactly one cycle.
// From the accepting edge to the edge that takes the result, the pipeline
// holds 10 stages for the sine and cosine series (one multiplier per
// Horner step), two rounding multiplier levels of 2 stages each for the
// angle products, and one stage for the sums and saturation.
// Throughput is one word per cycle; results leave in the order started.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// Reset clears every valid bit, so no result appears for words in flight;
// the block holds no other state.
module euler_angles_to_basis_vectors #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ANGLE_BITS-1:0]       pitch_i,
  input  logic [ANGLE_BITS-1:0]       yaw_i,
  input  logic [ANGLE_BITS-1:0]       roll_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic signed [FRAC_BITS+1:0] fwd_x_o,
  output logic signed [FRAC_BITS+1:0] fwd_y_o,
  output logic signed [FRAC_BITS+1:0] fwd_z_o,
  output logic signed [FRAC_BITS+1:0] right_x_o,
  output logic signed [FRAC_BITS+1:0] right_y_o,
  output logic signed [FRAC_BITS+1:0] right_z_o,
  output logic signed [FRAC_BITS+1:0] up_x_o,
  output logic signed [FRAC_BITS+1:0] up_y_o,
  output logic signed [FRAC_BITS+1:0] up_z_o
);
  import eabv_pkg::*;

  localparam int unsigned OutW    = FRAC_BITS + 2;
  localparam int unsigned Latency = ScLatency + 2 * QmulLatency + 1;
  localparam logic signed [OutW-1:0] QOne = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [OutW:0]   OneW = {3'b001, {FRAC_BITS{1'b0}}};

  // Products of the first level.
  localparam int unsigned IdxSrSp = 0;
  localparam int unsigned IdxCrSp = 1;
  localparam int unsigned IdxCpCy = 2;
  localparam int unsigned IdxCpSy = 3;
  localparam int unsigned IdxCrSy = 4;
  localparam int unsigned IdxCrCy = 5;
  localparam int unsigned IdxSrCp = 6;
  localparam int unsigned IdxSrSy = 7;
  localparam int unsigned IdxSrCy = 8;
  localparam int unsigned IdxCrCp = 9;
  localparam int unsigned NumL1   = 10;

  // Products of the second level.
  localparam int unsigned IdxSrSpCy = 0;
  localparam int unsigned IdxSrSpSy = 1;
  localparam int unsigned IdxCrSpCy = 2;
  localparam int unsigned IdxCrSpSy = 3;
  localparam int unsigned NumL2     = 4;

  // Result components.
  localparam int unsigned OutFwdX   = 0;
  localparam int unsigned OutFwdY   = 1;
  localparam int unsigned OutFwdZ   = 2;
  localparam int unsigned OutRightX = 3;
  localparam int unsigned OutRightY = 4;
  localparam int unsigned OutRightZ = 5;
  localparam int unsigned OutUpX    = 6;
  localparam int unsigned OutUpY    = 7;
  localparam int unsigned OutUpZ    = 8;
  localparam int unsigned NumOut    = 9;

  logic                   accept;
  logic [2:0]             sc_vld;
  logic                   l1_in_vld;
  logic signed [OutW-1:0] sp, cp, sy, cy, sr, cr;
  logic signed [OutW-1:0] l1_a [NumL1];
  logic signed [OutW-1:0] l1_b [NumL1];
  logic signed [OutW-1:0] l1_p [NumL1];
  logic [NumL1-1:0]       l1_vld;
  logic signed [OutW-1:0] l2_a [NumL2];
  logic signed [OutW-1:0] l2_b [NumL2];
  logic signed [OutW-1:0] l2_p [NumL2];
  logic [NumL2-1:0]       l2_vld;

  logic signed [OutW-1:0] sp_dly_q [2*QmulLatency];
  logic signed [OutW-1:0] sy_dly_q [QmulLatency];
  logic signed [OutW-1:0] cy_dly_q [QmulLatency];
  logic signed [OutW-1:0] l1_dly_q [QmulLatency][NumL1];
  logic signed [OutW-1:0] res_d    [NumOut];
  logic signed [OutW-1:0] res_q    [NumOut];
  logic                   done_q;

  // The pipeline never stalls, so every start is taken.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Sine and cosine of each angle.
  eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_pitch (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(pitch_i),
    .valid_o(sc_vld[0]), .sin_o(sp), .cos_o(cp)
  );
  eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_yaw (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(yaw_i),
    .valid_o(sc_vld[1]), .sin_o(sy), .cos_o(cy)
  );
  eabv_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_roll (
    .clk_i, .rst_ni, .valid_i(accept), .angle_i(roll_i),
    .valid_o(sc_vld[2]), .sin_o(sr), .cos_o(cr)
  );

  assign l1_in_vld = &sc_vld;

  // Operands of the first product level.
  always_comb begin
    l1_a[IdxSrSp] = sr;  l1_b[IdxSrSp] = sp;
    l1_a[IdxCrSp] = cr;  l1_b[IdxCrSp] = sp;
    l1_a[IdxCpCy] = cp;  l1_b[IdxCpCy] = cy;
    l1_a[IdxCpSy] = cp;  l1_b[IdxCpSy] = sy;
    l1_a[IdxCrSy] = cr;  l1_b[IdxCrSy] = sy;
    l1_a[IdxCrCy] = cr;  l1_b[IdxCrCy] = cy;
    l1_a[IdxSrCp] = sr;  l1_b[IdxSrCp] = cp;
    l1_a[IdxSrSy] = sr;  l1_b[IdxSrSy] = sy;
    l1_a[IdxSrCy] = sr;  l1_b[IdxSrCy] = cy;
    l1_a[IdxCrCp] = cr;  l1_b[IdxCrCp] = cp;
  end

  for (genvar i = 0; i < NumL1; i++) begin : g_l1
    eabv_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
      .clk_i, .rst_ni, .valid_i(l1_in_vld), .a_i(l1_a[i]), .b_i(l1_b[i]),
      .valid_o(l1_vld[i]), .p_o(l1_p[i])
    );
  end

  // Operands of the second level: the pitch-roll products times yaw terms.
  always_comb begin
    l2_a[IdxSrSpCy] = l1_p[IdxSrSp];  l2_b[IdxSrSpCy] = cy_dly_q[QmulLatency-1];
    l2_a[IdxSrSpSy] = l1_p[IdxSrSp];  l2_b[IdxSrSpSy] = sy_dly_q[QmulLatency-1];
    l2_a[IdxCrSpCy] = l1_p[IdxCrSp];  l2_b[IdxCrSpCy] = cy_dly_q[QmulLatency-1];
    l2_a[IdxCrSpSy] = l1_p[IdxCrSp];  l2_b[IdxCrSpSy] = sy_dly_q[QmulLatency-1];
  end

  for (genvar i = 0; i < NumL2; i++) begin : g_l2
    eabv_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
      .clk_i, .rst_ni, .valid_i(&l1_vld), .a_i(l2_a[i]), .b_i(l2_b[i]),
      .valid_o(l2_vld[i]), .p_o(l2_p[i])
    );
  end

  // Delay lines that keep the operands level with the multiplier outputs.
  always_ff @(posedge clk_i) begin
    sp_dly_q[0] <= sp;
    sy_dly_q[0] <= sy;
    cy_dly_q[0] <= cy;
    l1_dly_q[0] <= l1_p;
    for (int i = 1; i < 2 * QmulLatency; i++) begin
      sp_dly_q[i] <= sp_dly_q[i-1];
    end
    for (int i = 1; i < QmulLatency; i++) begin
      sy_dly_q[i] <= sy_dly_q[i-1];
      cy_dly_q[i] <= cy_dly_q[i-1];
      l1_dly_q[i] <= l1_dly_q[i-1];
    end
  end

  function automatic logic signed [OutW:0] ext(input logic signed [OutW-1:0] v);
    return $signed({v[OutW-1], v});
  endfunction

  function automatic logic signed [OutW-1:0] sat(input logic signed [OutW:0] v);
    logic signed [OutW-1:0] r;
    if (v > OneW) begin
      r = QOne;
    end else if (v < -OneW) begin
      r = -QOne;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  // Result components; the x and y sums of the right and up vectors are saturated to plus or minus one.
  always_comb begin
    res_d[OutFwdX]   = l1_dly_q[QmulLatency-1][IdxCpCy];
    res_d[OutFwdY]   = l1_dly_q[QmulLatency-1][IdxCpSy];
    res_d[OutFwdZ]   = -sp_dly_q[2*QmulLatency-1];
    res_d[OutRightX] = sat(-ext(l2_p[IdxSrSpCy]) + ext(l1_dly_q[QmulLatency-1][IdxCrSy]));
    res_d[OutRightY] = sat(-ext(l2_p[IdxSrSpSy]) - ext(l1_dly_q[QmulLatency-1][IdxCrCy]));
    res_d[OutRightZ] = -l1_dly_q[QmulLatency-1][IdxSrCp];
    res_d[OutUpX]    = sat(ext(l2_p[IdxCrSpCy]) + ext(l1_dly_q[QmulLatency-1][IdxSrSy]));
    res_d[OutUpY]    = sat(ext(l2_p[IdxCrSpSy]) - ext(l1_dly_q[QmulLatency-1][IdxSrCy]));
    res_d[OutUpZ]    = l1_dly_q[QmulLatency-1][IdxCrCp];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= &l2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o    = done_q;
  assign fwd_x_o   = res_q[OutFwdX];
  assign fwd_y_o   = res_q[OutFwdY];
  assign fwd_z_o   = res_q[OutFwdZ];
  assign right_x_o = res_q[OutRightX];
  assign right_y_o = res_q[OutRightY];
  assign right_z_o = res_q[OutRightZ];
  assign up_x_o    = res_q[OutUpX];
  assign up_y_o    = res_q[OutUpY];
  assign up_z_o    = res_q[OutUpZ];

  // Every accepted word yields its result after the fixed latency.
  a_word_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted word produced no result");

  // No result appears without a word started the latency earlier.
  a_done_started : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a matching start");

  // The saturated right x and up y sums stay within plus or minus one.
  a_sum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (right_x_o <= QOne) && (right_x_o >= -QOne) &&
               (up_y_o <= QOne) && (up_y_o >= -QOne))
    else $error("vector component beyond unit range");

endmodule

`default_nettype wire
